// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the record deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/ord_pkg.sv -----
// ----------------------------------------------------------------------------
// Object record deframer package
// Shared types and result codes.
// ----------------------------------------------------------------------------
package ord_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t K_PAYLOAD = 3'd0;
    localparam kind_t K_OK      = 3'd1;
    localparam kind_t K_CKSUM   = 3'd2;
    localparam kind_t K_FORMAT  = 3'd3;
    localparam kind_t K_EOF     = 3'd4;
    localparam kind_t K_LONG    = 3'd5;

    localparam logic [7:0]  SYNC_BYTE         = 8'd1;
    localparam logic [15:0] HEADER_BYTES      = 16'd6;
    localparam logic [15:0] RESET_MAX_PAYLOAD = 16'd800;

    // One raw stream byte held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       at_end;
    } item_t;

endpackage

// ----- rtl/ord_byte_if.sv -----
// ----------------------------------------------------------------------------
// Byte stream channel
// valid/ready channel carrying one raw object-file byte per request.
// ----------------------------------------------------------------------------
interface ord_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       at_end;

    modport source (output valid, output data_byte, output at_end, input ready);
    modport sink   (input valid, input data_byte, input at_end, output ready);
endinterface

// ----- rtl/ord_rec_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// valid/ready channel carrying payload bytes and record status.
// ----------------------------------------------------------------------------
interface ord_rec_if;
    logic          valid;
    logic          ready;
    ord_pkg::kind_t kind;
    logic [7:0]    payload_byte;
    logic [7:0]    record_type;

    modport source (output valid, output kind, output payload_byte, output record_type,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input record_type,
                    output ready);
endinterface

// ----- rtl/ord_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// valid/ready channel carrying the max_payload register write data.
// ----------------------------------------------------------------------------
interface ord_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink   (input valid, input max_payload, output ready);
endinterface

// ----- rtl/ord_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module ord_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    ord_byte_if.sink       stream,
    output logic           item_valid,
    output ord_pkg::item_t item,
    input  logic           item_take
);
    import ord_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  load;

    // Refill when empty, or whenever the held item leaves in the same cycle
    assign stream.ready = !valid_reg || item_take;
    assign load         = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{data_byte: stream.data_byte, at_end: stream.at_end};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/ord_core.sv -----
// ----------------------------------------------------------------------------
// Record parser
// Per-byte phase update, checksum and length tracking, and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ord_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  ord_pkg::item_t item,
    output logic           item_take,
    ord_cfg_if.sink        cfg,
    ord_rec_if.source      result
);
    import ord_pkg::*;

    localparam logic [3:0] PH_SYNC    = 4'd0;
    localparam logic [3:0] PH_SECOND  = 4'd1;
    localparam logic [3:0] PH_PAD_A   = 4'd2;
    localparam logic [3:0] PH_LEN_LO  = 4'd3;
    localparam logic [3:0] PH_LEN_HI  = 4'd4;
    localparam logic [3:0] PH_TYPE    = 4'd5;
    localparam logic [3:0] PH_PAD_B   = 4'd6;
    localparam logic [3:0] PH_PAYLOAD = 4'd7;
    localparam logic [3:0] PH_CHECK   = 4'd8;

    logic [3:0]  phase_reg,       phase_next;
    logic [15:0] bytes_left_reg,  bytes_left_next;
    logic [7:0]  sum_reg,         sum_next;
    logic [7:0]  type_reg,        type_next;
    logic        first_zero_reg,  first_zero_next;
    logic        ended_reg,       ended_next;
    logic [15:0] max_payload_reg;

    logic        out_valid_reg;
    kind_t       kind_reg,        kind_next;
    logic [7:0]  pbyte_reg,       pbyte_next;
    logic [7:0]  rtype_reg;
    logic        emit;

    logic        in_record;
    logic [7:0]  eff_byte;
    logic [7:0]  sum_add;
    logic [15:0] rec_len;
    logic [15:0] pay_cnt;
    logic [15:0] left_dec;
    logic        out_free;

    assign in_record = (phase_reg >= PH_PAD_A) && (phase_reg <= PH_CHECK);
    // End of input inside a record reads as 0xFF
    assign eff_byte  = (item.at_end && in_record) ? 8'hFF : item.data_byte;
    assign sum_add   = sum_reg + eff_byte;
    assign rec_len   = {eff_byte, bytes_left_reg[7:0]};
    assign pay_cnt   = (rec_len >= HEADER_BYTES) ? (rec_len - HEADER_BYTES) : 16'd0;
    assign left_dec  = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        type_next       = type_reg;
        first_zero_next = first_zero_reg;
        ended_next      = ended_reg;
        emit            = 1'b0;
        kind_next       = K_PAYLOAD;
        pbyte_next      = 8'd0;

        if (in_record && item.at_end)
        begin
            ended_next = 1'b1;
        end

        unique case (phase_reg)
            PH_SECOND:
            begin
                phase_next = PH_SYNC;
                emit       = 1'b1;
                if (item.at_end)
                begin
                    ended_next = 1'b1;
                end
                if (first_zero_reg && (item.at_end || item.data_byte == 8'd0))
                begin
                    ended_next = 1'b1;
                    kind_next  = K_EOF;
                end
                else
                begin
                    kind_next = K_FORMAT;
                end
            end
            PH_PAD_A:
            begin
                sum_next   = sum_add;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                sum_next        = sum_add;
                bytes_left_next = {8'd0, eff_byte};
                phase_next      = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                sum_next = sum_add;
                if (pay_cnt > max_payload_reg)
                begin
                    bytes_left_next = 16'd0;
                    phase_next      = PH_SYNC;
                    emit            = 1'b1;
                    kind_next       = K_LONG;
                end
                else
                begin
                    bytes_left_next = pay_cnt;
                    phase_next      = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                sum_next   = sum_add;
                type_next  = eff_byte;
                phase_next = PH_PAD_B;
            end
            PH_PAD_B:
            begin
                sum_next   = sum_add;
                phase_next = (bytes_left_reg == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_next        = sum_add;
                bytes_left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    phase_next = PH_CHECK;
                end
                emit       = 1'b1;
                kind_next  = K_PAYLOAD;
                pbyte_next = eff_byte;
            end
            PH_CHECK:
            begin
                sum_next   = sum_add;
                phase_next = PH_SYNC;
                emit       = 1'b1;
                kind_next  = (sum_add == 8'd0) ? K_OK : K_CKSUM;
            end
            default:
            begin
                // Awaiting sync; unused codes land here too
                phase_next = PH_SYNC;
                if (item.at_end)
                begin
                    ended_next = 1'b1;
                    emit       = 1'b1;
                    kind_next  = K_EOF;
                end
                else if (item.data_byte == SYNC_BYTE)
                begin
                    sum_next   = SYNC_BYTE;
                    phase_next = PH_PAD_A;
                end
                else if (ended_reg)
                begin
                    emit      = 1'b1;
                    kind_next = K_EOF;
                end
                else
                begin
                    first_zero_next = (item.data_byte == 8'd0);
                    phase_next      = PH_SECOND;
                end
            end
        endcase
    end

    // Hold the item only when it makes a result and the result register is full and not being read
    assign out_free  = !out_valid_reg || result.ready;
    assign item_take = item_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC;
            bytes_left_reg  <= 16'd0;
            sum_reg         <= 8'd0;
            type_reg        <= 8'd0;
            first_zero_reg  <= 1'b0;
            ended_reg       <= 1'b0;
            max_payload_reg <= RESET_MAX_PAYLOAD;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_payload_reg <= cfg.max_payload;
            end
            if (item_take)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                sum_reg        <= sum_next;
                type_reg       <= type_next;
                first_zero_reg <= first_zero_next;
                ended_reg      <= ended_next;
            end
            if (out_free)
            begin
                out_valid_reg <= item_take && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && emit)
        begin
            kind_reg  <= kind_next;
            pbyte_reg <= pbyte_next;
            rtype_reg <= type_reg;
        end
    end

    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.kind         = kind_reg;
    assign result.payload_byte = pbyte_reg;
    assign result.record_type  = rtype_reg;

    `ASSERT_IMPLY(a_payload_count, clk, rst_n, phase_reg == PH_PAYLOAD, bytes_left_reg != 16'd0)
    `ASSERT_IMPLY(a_status_no_byte, clk, rst_n, out_valid_reg && kind_reg != K_PAYLOAD, pbyte_reg == 8'd0)
    `ASSERT_NEXT(a_ended_sticky, clk, rst_n, ended_reg, ended_reg)

endmodule

// ----- rtl/object_record_deframer_top.sv -----
// ----------------------------------------------------------------------------
// Object record deframer
// Splits an object-file byte stream into tagged payload bytes and record status.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless a result stalls on result.ready, and gives at
// most one result per byte, in order: each payload byte as kind 0 tagged with
// the record type, then one status (ok, checksum bad, bad format, too long or
// end of file). A byte passes the input register, then the result register;
// the parser's phase update sets the rate, and bytes that make no result pass
// while a result waits. No clearing pass after reset. The user must write
// max_payload only while the stream is idle; the block does not enforce it.
module object_record_deframer_top (
    input  logic      clk,
    input  logic      rst_n,
    ord_byte_if.sink  stream,
    ord_cfg_if.sink   cfg,
    ord_rec_if.source result
);
    import ord_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_take;

    ord_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ord_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .cfg        (cfg),
        .result     (result)
    );

endmodule
